FILE: hdl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_DONE     = 3'd1,
    ST_EXP_QUOT = 3'd2,
    ST_BAD_ESC  = 3'd3,
    ST_SHORT_U  = 3'd4,
    ST_BAD_HEX  = 3'd5,
    ST_BAD_CHAR = 3'd6,
    ST_UNTERM   = 3'd7
  } status_e;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic        flush_en;
    logic [15:0] flush_cp;
    logic        cp_en;
    logic        cp_raw;
    logic [20:0] cp;
    logic        st_en;
    status_e     st;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/jsu_front.sv
// Front end: string state machine that turns each input byte into at most one emit command.
`timescale 1ns / 1ps
`default_nettype none
module jsu_front import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    PH_WAIT, PH_BODY, PH_ESC, PH_HEX, PH_HIGH, PH_HIGH_ESC
  } phase_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        bad_q, bad_d;
  logic [15:0] ph_q, ph_d;
  logic        pv_q, pv_d;

  logic [3:0]  hex_v;
  logic        hex_ok;
  logic [15:0] acc_new;
  logic        bad_new;
  logic        do_body, do_esc, do_code;
  logic [15:0] code;
  cmd_t        cmd;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_v = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      hex_v = byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
    acc_new = {acc_q[11:0], hex_v};
    bad_new = bad_q | ~hex_ok;
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    bad_d   = bad_q;
    ph_d    = ph_q;
    pv_d    = pv_q;
    cmd     = '0;
    do_body = 1'b0;
    do_esc  = 1'b0;
    do_code = 1'b0;
    code    = acc_new;
    if (accept_i) begin
      if (end_i) begin
        phase_d = PH_WAIT;
        case (phase_q)
          PH_BODY: begin
            cmd.st_en = 1'b1; cmd.st = ST_UNTERM; pv_d = 1'b0;
          end
          PH_ESC: begin
            cmd.st_en = 1'b1; cmd.st = ST_BAD_ESC; pv_d = 1'b0;
          end
          PH_HEX: begin
            cmd.flush_en = pv_q; cmd.flush_cp = ph_q;
            cmd.st_en = 1'b1; cmd.st = ST_SHORT_U; pv_d = 1'b0;
          end
          PH_HIGH: begin
            cmd.flush_en = pv_q; cmd.flush_cp = ph_q;
            cmd.st_en = 1'b1; cmd.st = ST_UNTERM; pv_d = 1'b0;
          end
          PH_HIGH_ESC: begin
            cmd.flush_en = pv_q; cmd.flush_cp = ph_q;
            cmd.st_en = 1'b1; cmd.st = ST_BAD_ESC; pv_d = 1'b0;
          end
          default: begin
          end
        endcase
      end else begin
        case (phase_q)
          PH_BODY: do_body = 1'b1;
          PH_ESC:  do_esc  = 1'b1;
          PH_HEX: begin
            acc_d = acc_new;
            bad_d = bad_new;
            cnt_d = cnt_q + 2'd1;
            if (cnt_q == 2'd3) begin
              if (bad_new) begin
                cmd.flush_en = pv_q; cmd.flush_cp = ph_q;
                cmd.st_en = 1'b1; cmd.st = ST_BAD_HEX;
                pv_d = 1'b0; phase_d = PH_WAIT;
              end else begin
                do_code = 1'b1;
              end
            end
          end
          PH_HIGH: begin
            if (byte_i == CH_BSL) begin
              phase_d = PH_HIGH_ESC;
            end else begin
              cmd.flush_en = pv_q; cmd.flush_cp = ph_q; pv_d = 1'b0;
              do_body = 1'b1;
            end
          end
          PH_HIGH_ESC: begin
            if (byte_i == CH_U) begin
              phase_d = PH_HEX; acc_d = '0; cnt_d = '0; bad_d = 1'b0;
            end else begin
              cmd.flush_en = pv_q; cmd.flush_cp = ph_q; pv_d = 1'b0;
              do_esc = 1'b1;
            end
          end
          default: begin
            if (byte_i == CH_QUOTE) begin
              phase_d = PH_BODY;
            end else begin
              phase_d = PH_WAIT; pv_d = 1'b0;
              cmd.st_en = 1'b1; cmd.st = ST_EXP_QUOT;
            end
          end
        endcase
      end
    end

    if (do_code) begin
      phase_d = PH_BODY;
      if (pv_q && code >= 16'hDC00 && code <= 16'hDFFF) begin
        cmd.cp_en = 1'b1;
        cmd.cp    = 21'h10000 + {1'b0, ph_q[9:0], code[9:0]};
        pv_d      = 1'b0;
      end else begin
        cmd.flush_en = pv_q; cmd.flush_cp = ph_q; pv_d = 1'b0;
        if (code >= 16'hD800 && code <= 16'hDBFF) begin
          ph_d = code; pv_d = 1'b1; phase_d = PH_HIGH;
        end else begin
          cmd.cp_en = 1'b1; cmd.cp = {5'd0, code};
        end
      end
    end

    if (do_body) begin
      phase_d = PH_BODY;
      if (byte_i == CH_QUOTE) begin
        cmd.st_en = 1'b1; cmd.st = ST_DONE; phase_d = PH_WAIT;
      end else if (byte_i == CH_BSL) begin
        phase_d = PH_ESC;
      end else begin
        cmd.cp_en = 1'b1; cmd.cp_raw = 1'b1; cmd.cp = {13'd0, byte_i};
      end
    end

    if (do_esc) begin
      phase_d = PH_BODY;
      case (byte_i)
        CH_QUOTE, CH_BSL, CH_SLASH: begin
          cmd.cp_en = 1'b1; cmd.cp = {13'd0, byte_i};
        end
        CH_B: begin cmd.cp_en = 1'b1; cmd.cp = 21'h08; end
        CH_F: begin cmd.cp_en = 1'b1; cmd.cp = 21'h0C; end
        CH_N: begin cmd.cp_en = 1'b1; cmd.cp = 21'h0A; end
        CH_R: begin cmd.cp_en = 1'b1; cmd.cp = 21'h0D; end
        CH_T: begin cmd.cp_en = 1'b1; cmd.cp = 21'h09; end
        CH_U: begin
          phase_d = PH_HEX; acc_d = '0; cnt_d = '0; bad_d = 1'b0;
        end
        default: begin
          cmd.st_en = 1'b1; cmd.st = ST_BAD_CHAR;
          phase_d = PH_WAIT; pv_d = 1'b0;
        end
      endcase
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i & (cmd.flush_en | cmd.cp_en | cmd.st_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      acc_q   <= '0;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
      ph_q    <= '0;
      pv_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
      ph_q    <= ph_d;
      pv_q    <= pv_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/jsu_queue.sv
// Command queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module jsu_queue import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/jsu_back.sv
// Back end: expands one command into UTF-8 bytes and any closing status, one per cycle while out_ready_i is high.
`timescale 1ns / 1ps
`default_nettype none
module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output status_e    out_status_o,
  output logic       out_last_o
);

  cmd_t       cur_q;
  logic       cur_valid_q;
  logic [2:0] idx_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  status_e    out_status_q;
  logic       out_last_q;

  logic [7:0] fb [3];
  logic [7:0] cb [4];
  logic [2:0] fn, cn, sn, n, j;
  logic [7:0] sel_byte;
  status_e    sel_st;
  logic       sel_last;
  logic       adv;
  logic [20:0] cp;

  always_comb begin
    cp    = cur_q.cp;
    fb[0] = {4'hE, cur_q.flush_cp[15:12]};
    fb[1] = {2'b10, cur_q.flush_cp[11:6]};
    fb[2] = {2'b10, cur_q.flush_cp[5:0]};
    cb[0] = cp[7:0];
    cb[1] = 8'h00;
    cb[2] = 8'h00;
    cb[3] = 8'h00;
    if (cur_q.cp_raw || cp < 21'h80) begin
      cn = 3'd1;
    end else if (cp < 21'h800) begin
      cn    = 3'd2;
      cb[0] = {3'b110, cp[10:6]};
      cb[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      cn    = 3'd3;
      cb[0] = {4'hE, cp[15:12]};
      cb[1] = {2'b10, cp[11:6]};
      cb[2] = {2'b10, cp[5:0]};
    end else begin
      cn    = 3'd4;
      cb[0] = {5'b11110, cp[20:18]};
      cb[1] = {2'b10, cp[17:12]};
      cb[2] = {2'b10, cp[11:6]};
      cb[3] = {2'b10, cp[5:0]};
    end
    if (!cur_q.cp_en) begin
      cn = 3'd0;
    end
    fn = cur_q.flush_en ? 3'd3 : 3'd0;
    sn = cur_q.st_en ? 3'd1 : 3'd0;
    n  = fn + cn + sn;
    j  = idx_q - fn;
    if (idx_q < fn) begin
      sel_byte = fb[idx_q[1:0]];
      sel_st   = ST_BYTE;
    end else if (j < cn) begin
      sel_byte = cb[j[1:0]];
      sel_st   = ST_BYTE;
    end else begin
      sel_byte = 8'h00;
      sel_st   = cur_q.st;
    end
    sel_last = (idx_q == n - 3'd1);
  end

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = q_valid_i && (!cur_valid_q || (adv && sel_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= cur_valid_q;
      end
      if (adv && cur_valid_q) begin
        idx_q <= sel_last ? 3'd0 : idx_q + 3'd1;
      end
      if (pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (adv && cur_valid_q && sel_last) begin
        cur_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_cmd_i;
    end
    if (adv && cur_valid_q) begin
      out_byte_q   <= sel_byte;
      out_status_q <= sel_st;
      out_last_q   <= sel_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule
`default_nettype wire

FILE: hdl/json_string_unescape_utf8.sv
// JSON string unescaper: raw text bytes in, decoded UTF-8 bytes and a status out.
//
// Input stream: s_axis_tdata carries one raw text byte, s_axis_tlast marks the end
// of the text and then carries no byte. Output stream: m_axis_tdata is a decoded
// byte, m_axis_tuser the status (zero for a byte, else done or an error code, with
// a zero data byte), m_axis_tlast flags the final result caused by an input byte.
// An input byte may cause no result or up to six.
// Throughput: one input byte per cycle while each byte causes at most one result and
// the receiver is ready; an input byte with several results occupies the output
// sequencer until all its results are out, and a four-entry command queue absorbs
// such bursts. The input stalls only when that queue is full.
// Reset clears the decode state (waiting for an opening quote), the queue and the
// output valid flag. When the receiver stalls, the output register holds its result,
// the sequencer and queue back up, and s_axis_tready falls once the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [2:0] status
  output logic       m_axis_tlast
);

  logic    accept, push, full, pop, q_valid;
  cmd_t    push_cmd, q_cmd;
  status_e out_st;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .end_i    (s_axis_tlast),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  jsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_status_o (out_st),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = out_st;

endmodule
`default_nettype wire

FILE: hdl/jsu_checker.sv
// Port-level checks of the JSON string unescaper and their binding.
`timescale 1ns / 1ps
`default_nettype none
module jsu_checker import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic [2:0] m_axis_tuser,
  input  logic       m_axis_tlast
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output transfer changed");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_BYTE |-> m_axis_tlast)
    else $error("status result not final");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_BYTE |-> m_axis_tdata == 8'h00)
    else $error("status result carries a data byte");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the JSON string unescaper with a UTF-8 decoding scoreboard.
`timescale 1ns / 1ps
module tb;
  import jsu_pkg::*;

  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned ITEM_COUNT  = 200;
  localparam int unsigned CALM_FROM   = 160;
  localparam int unsigned HIGH_MIN    = 'hD800;
  localparam int unsigned HIGH_MAX    = 'hDBFF;
  localparam int unsigned LOW_MIN     = 'hDC00;
  localparam int unsigned LOW_MAX     = 'hDFFF;
  localparam logic [7:0]  CH_QUOTE    = 8'h22;
  localparam logic [7:0]  CH_BSLASH   = 8'h5C;
  localparam logic [7:0]  CH_U        = 8'h75;
  localparam logic [7:0]  ESC_CHARS [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E,
                                             8'h72, 8'h74};

  typedef enum logic [2:0] {
    PH_WAIT, PH_BODY, PH_ESC, PH_HEX, PH_HIGH, PH_HIGH_ESC
  } phase_e;

  typedef struct {
    logic [7:0] data;
    status_e    st;
    logic       last;
  } result_t;

  class utf8_scoreboard;
    phase_e      phase;
    logic [15:0] code;
    int unsigned digits;
    bit          bad_digit;
    logic [15:0] high_cp;
    bit          high_held;
    result_t     step_q[$];
    result_t     pending_q[$];
    int unsigned mismatches;
    int unsigned inputs;
    int unsigned results;

    function new();
      phase      = PH_WAIT;
      code       = '0;
      digits     = 0;
      bad_digit  = 0;
      high_cp    = '0;
      high_held  = 0;
      mismatches = 0;
      inputs     = 0;
      results    = 0;
    endfunction

    function void put(logic [7:0] b, status_e st);
      result_t r;
      r.data = b;
      r.st   = st;
      r.last = 1'b0;
      if (step_q.size() < MAX_RESULTS) step_q.insert(step_q.size(), r);
    endfunction

    function void emit_utf8(int unsigned cp);
      if (cp < 'h80) begin
        put(cp[7:0], ST_BYTE);
      end else if (cp < 'h800) begin
        put(8'hC0 | cp[10:6], ST_BYTE);
        put(8'h80 | cp[5:0], ST_BYTE);
      end else if (cp < 'h10000) begin
        put(8'hE0 | cp[15:12], ST_BYTE);
        put(8'h80 | cp[11:6], ST_BYTE);
        put(8'h80 | cp[5:0], ST_BYTE);
      end else begin
        put(8'hF0 | cp[20:18], ST_BYTE);
        put(8'h80 | cp[17:12], ST_BYTE);
        put(8'h80 | cp[11:6], ST_BYTE);
        put(8'h80 | cp[5:0], ST_BYTE);
      end
    endfunction

    function void fail(status_e st);
      put(8'h00, st);
      phase     = PH_WAIT;
      high_held = 0;
    endfunction

    function void flush_high();
      if (high_held) begin
        emit_utf8(high_cp);
        high_held = 0;
      end
    endfunction

    function void begin_code();
      phase     = PH_HEX;
      code      = '0;
      digits    = 0;
      bad_digit = 0;
    endfunction

    function void body_byte(logic [7:0] b);
      phase = PH_BODY;
      if (b == CH_QUOTE) begin
        put(8'h00, ST_DONE);
        phase = PH_WAIT;
      end else if (b == CH_BSLASH) begin
        phase = PH_ESC;
      end else begin
        put(b, ST_BYTE);
      end
    endfunction

    function void escape_byte(logic [7:0] b);
      phase = PH_BODY;
      case (b)
        8'h22, 8'h5C, 8'h2F: put(b, ST_BYTE);
        8'h62: put(8'h08, ST_BYTE);
        8'h66: put(8'h0C, ST_BYTE);
        8'h6E: put(8'h0A, ST_BYTE);
        8'h72: put(8'h0D, ST_BYTE);
        8'h74: put(8'h09, ST_BYTE);
        CH_U: begin_code();
        default: fail(ST_BAD_CHAR);
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic e);
      logic [3:0] v;
      step_q.delete();
      inputs++;
      if (e) begin
        case (phase)
          PH_BODY: fail(ST_UNTERM);
          PH_ESC: fail(ST_BAD_ESC);
          PH_HEX: begin
            flush_high();
            fail(ST_SHORT_U);
          end
          PH_HIGH: begin
            flush_high();
            fail(ST_UNTERM);
          end
          PH_HIGH_ESC: begin
            flush_high();
            fail(ST_BAD_ESC);
          end
          default: phase = PH_WAIT;
        endcase
      end else begin
        case (phase)
          PH_BODY: body_byte(b);
          PH_ESC: escape_byte(b);
          PH_HEX: begin
            v = 4'h0;
            if (b >= "0" && b <= "9") v = 4'(b - "0");
            else if (b >= "a" && b <= "f") v = 4'(b - "a" + 10);
            else if (b >= "A" && b <= "F") v = 4'(b - "A" + 10);
            else bad_digit = 1;
            code = {code[11:0], v};
            digits++;
            if (digits == 4) begin
              digits = 0;
              if (bad_digit) begin
                flush_high();
                fail(ST_BAD_HEX);
              end else begin
                phase = PH_BODY;
                if (high_held && code >= LOW_MIN && code <= LOW_MAX) begin
                  emit_utf8('h10000 + ((high_cp - HIGH_MIN) << 10) + (code - LOW_MIN));
                  high_held = 0;
                end else begin
                  flush_high();
                  if (code >= HIGH_MIN && code <= HIGH_MAX) begin
                    high_cp   = code;
                    high_held = 1;
                    phase     = PH_HIGH;
                  end else begin
                    emit_utf8(code);
                  end
                end
              end
            end
          end
          PH_HIGH: begin
            if (b == CH_BSLASH) begin
              phase = PH_HIGH_ESC;
            end else begin
              flush_high();
              body_byte(b);
            end
          end
          PH_HIGH_ESC: begin
            if (b == CH_U) begin
              begin_code();
            end else begin
              flush_high();
              escape_byte(b);
            end
          end
          default: begin
            if (b == CH_QUOTE) phase = PH_BODY;
            else fail(ST_EXP_QUOT);
          end
        endcase
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) pending_q.insert(pending_q.size(), step_q[i]);
    endfunction

    function void check_result(logic [7:0] d, logic [2:0] u, logic l);
      result_t want;
      results++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: out_byte %0h status %0d is_last %0d", d, u, l);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      if (d !== want.data) begin
        $error("out_byte: expected %0h, actual %0h", want.data, d);
        mismatches++;
      end
      if (u !== want.st) begin
        $error("status: expected %0d, actual %0d", want.st, u);
        mismatches++;
      end
      if (l !== want.last) begin
        $error("is_last: expected %0d, actual %0d", want.last, l);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic [2:0] m_axis_tuser;   // [2:0] status
  logic       m_axis_tlast;

  utf8_scoreboard sb;
  bit             tx_idle_on;
  bit             rx_idle_on;
  int unsigned    counted_items;
  int unsigned    strings_sent;
  int unsigned    stuck_cycles;

  json_string_unescape_utf8 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic e, input bit ignored = 0);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= e;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!ignored) counted_items++;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return "0" + n;
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
    return b;
  endfunction

  // Send a backslash-u escape; a corrupt one has one digit replaced by a non-hex byte.
  task automatic send_code(input logic [15:0] cp, input bit corrupt);
    int unsigned bad_pos;
    bad_pos = $urandom_range(0, 3);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) begin
      if (corrupt && bad_pos == i) send_item(non_hex(), 1'b0);
      else send_item(hex_char(cp[i*4 +: 4]), 1'b0);
    end
  endtask

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 'h7F));
      1: return 16'($urandom_range('h80, 'h7FF));
      2: return 16'($urandom_range('h800, 'hFFFF));
      3: return 16'($urandom_range(HIGH_MIN, HIGH_MAX));
      4: return 16'($urandom_range(LOW_MIN, LOW_MAX));
      default: return 16'($urandom_range(0, 'hFFFF));
    endcase
  endfunction

  task automatic send_element(output bit ended);
    logic [7:0] b;
    ended = 0;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
        send_item(b, 1'b0);
      end
      4: begin
        send_item(CH_BSLASH, 1'b0);
        send_item(ESC_CHARS[$urandom_range(0, 7)], 1'b0);
      end
      5, 6, 7: send_code(pick_code(), 0);
      8, 9: begin
        send_code(16'($urandom_range(HIGH_MIN, HIGH_MAX)), 0);
        send_code(16'($urandom_range(LOW_MIN, LOW_MAX)), 0);
      end
      10: begin
        send_code(pick_code(), 1);
        ended = 1;
      end
      default: begin
        do b = 8'($urandom_range(0, 255));
        while (b == CH_U || b inside {ESC_CHARS});
        send_item(CH_BSLASH, 1'b0);
        send_item(b, 1'b0);
        ended = 1;
      end
    endcase
  endtask

  task automatic send_string();
    bit ended;
    int unsigned n;
    send_item(CH_QUOTE, 1'b0);
    n = $urandom_range(0, 8);
    ended = 0;
    for (int i = 0; i < n && !ended; i++) send_element(ended);
    if (ended) return;
    case ($urandom_range(0, 9))
      0: send_end();
      1: begin
        send_item(CH_BSLASH, 1'b0);
        send_end();
      end
      2: begin
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_U, 1'b0);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 3) == 0) send_item(non_hex(), 1'b0);
          else send_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
        end
        send_end();
      end
      default: send_item(CH_QUOTE, 1'b0);
    endcase
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    tx_idle_on    = 0;
    rx_idle_on    = 0;
    counted_items = 0;
    strings_sent  = 0;
    stuck_cycles  = 0;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1, 1);
    send_text("\"");
    send_item(8'h00, 1'b0);
    send_text("\\/\\q");
    send_text("\"\\");
    send_end();
    send_text("\"\\uZ");
    send_end();
    send_text("\"\\uD800");
    send_end();
    send_text("\"\"");
    wait_drained();

    while (counted_items < ITEM_COUNT) begin
      tx_idle_on = counted_items < CALM_FROM && $urandom_range(0, 3) != 0;
      rx_idle_on = counted_items < CALM_FROM && $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 7))
        0: send_item(8'($urandom_range(0, 255)) ^ (CH_QUOTE & 8'h00) | 8'h01, 1'b0);
        1: send_item(8'($urandom_range(0, 255)), 1'b1, 1);
        default: ;
      endcase
      send_string();
      strings_sent++;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    tx_idle_on = 0;
    rx_idle_on = 0;
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d random strings plus directed escapes, surrogates and error endings.",
             strings_sent);
    $display("Took %0d input transfers and checked %0d result transfers.",
             sb.inputs, sb.results);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
